[rtl/prpa_pkg.sv]
`timescale 1ns / 1ps
// Package for the pedestal, rms and pulse area block: widths, register
// indexes, the back-end state type and the result record.
// Depends on nothing; every other file of the block imports it.
package prpa_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_SAMPLES_DEF = 32;
  localparam int SAMPLE_BITS_DEF = 14;

  // Configuration port.
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_FIRST = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LAST  = 1'b1;
  localparam logic [CFG_W-1:0] WINDOW_FIRST_RST = 5'd0;
  localparam logic [CFG_W-1:0] WINDOW_LAST_RST  = 5'd5;

  // The window lies within positions 0 to 31, so it never holds more than 32 samples.
  localparam int NCNT_W = CFG_W + 1;
  localparam int NN_W   = 2 * NCNT_W - 1;

  // Result field widths.
  localparam int PED_W  = 18;
  localparam int RMS_W  = 17;
  localparam int AREA_W = 24;

  // Entries of the job queue between the front and the back end.
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [PED_W-1:0]  ped;
    logic [RMS_W-1:0]  rms;
    logic [AREA_W-1:0] area;
    logic              empty;
  } result_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_PDIV,
    B_SUB,
    B_RDIV,
    B_SQRT,
    B_FIN
  } back_state_t;

  function automatic int pos_w(input int max_samples);
    return $clog2(max_samples + 1);
  endfunction

  function automatic int sum_w(input int sample_bits);
    return sample_bits + CFG_W;
  endfunction

  function automatic int sq_w(input int sample_bits);
    return 2 * sample_bits + CFG_W;
  endfunction

  function automatic int tot_w(input int sample_bits, input int max_samples);
    return sample_bits + pos_w(max_samples);
  endfunction

  function automatic int job_w(input int sample_bits, input int max_samples);
    return NCNT_W + sum_w(sample_bits) + sq_w(sample_bits)
           + tot_w(sample_bits, max_samples) + pos_w(max_samples);
  endfunction

endpackage

[rtl/prpa_front.sv]
`timescale 1ns / 1ps
// Front end: window registers, and per-sample accumulation of window sum,
// window sum of squares, window count, total sum and position.
// Depends on prpa_pkg; feeds finished waveforms into prpa_queue.
module prpa_front #(
  parameter int MAX_SAMPLES = prpa_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = prpa_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [prpa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [prpa_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 in_push,
  input  logic                                 in_full,
  input  logic [13:0]                          in_sample_value,
  input  logic                                 in_last_sample,
  output logic                                 job_push,
  output logic [prpa_pkg::job_w(SAMPLE_BITS, MAX_SAMPLES)-1:0] job_data
);
  import prpa_pkg::*;

  localparam int CW   = pos_w(MAX_SAMPLES);
  localparam int SW   = sum_w(SAMPLE_BITS);
  localparam int QW   = sq_w(SAMPLE_BITS);
  localparam int TW   = tot_w(SAMPLE_BITS, MAX_SAMPLES);
  localparam int XQW  = 2 * SAMPLE_BITS;
  localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;

  logic [CFG_W-1:0]       win_first_r, win_first_nxt;
  logic [CFG_W-1:0]       win_last_r, win_last_nxt;
  logic [CW-1:0]          pos_r, pos_nxt, pos_upd;
  logic [SW-1:0]          win_sum_r, win_sum_nxt, win_sum_upd;
  logic [QW-1:0]          win_sq_r, win_sq_nxt, win_sq_upd;
  logic [NCNT_W-1:0]      win_cnt_r, win_cnt_nxt, win_cnt_upd;
  logic [TW-1:0]          tot_r, tot_nxt, tot_upd;
  logic [SAMPLE_BITS-1:0] x;
  logic [XQW-1:0]         x_sq;
  logic                   accept;
  logic                   in_range;
  logic                   in_win;

  assign accept   = in_push & ~in_full;
  assign x        = SAMPLE_BITS'(in_sample_value);
  assign x_sq     = XQW'(x) * XQW'(x);
  assign in_range = pos_r < CW'(MAX_SAMPLES);
  assign in_win   = (CMPW'(pos_r) >= CMPW'(win_first_r)) &&
                    (CMPW'(pos_r) <= CMPW'(win_last_r));

  always_comb begin
    win_first_nxt = win_first_r;
    win_last_nxt  = win_last_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_WINDOW_FIRST: win_first_nxt = cfg_data;
        CFG_WINDOW_LAST:  win_last_nxt  = cfg_data;
        default:          win_first_nxt = win_first_r;
      endcase
    end
  end

  always_comb begin
    pos_upd     = pos_r;
    win_sum_upd = win_sum_r;
    win_sq_upd  = win_sq_r;
    win_cnt_upd = win_cnt_r;
    tot_upd     = tot_r;
    // Samples beyond the maximum length are ignored apart from their last flag.
    if (in_range) begin
      if (in_win) begin
        win_sum_upd = win_sum_r + SW'(x);
        win_sq_upd  = win_sq_r + QW'(x_sq);
        win_cnt_upd = win_cnt_r + 1'b1;
      end
      tot_upd = tot_r + TW'(x);
      pos_upd = pos_r + 1'b1;
    end

    pos_nxt     = pos_r;
    win_sum_nxt = win_sum_r;
    win_sq_nxt  = win_sq_r;
    win_cnt_nxt = win_cnt_r;
    tot_nxt     = tot_r;
    job_push    = 1'b0;
    if (accept) begin
      if (in_last_sample) begin
        job_push    = 1'b1;
        pos_nxt     = '0;
        win_sum_nxt = '0;
        win_sq_nxt  = '0;
        win_cnt_nxt = '0;
        tot_nxt     = '0;
      end else begin
        pos_nxt     = pos_upd;
        win_sum_nxt = win_sum_upd;
        win_sq_nxt  = win_sq_upd;
        win_cnt_nxt = win_cnt_upd;
        tot_nxt     = tot_upd;
      end
    end
  end

  assign job_data = {win_cnt_upd, win_sum_upd, win_sq_upd, tot_upd, pos_upd};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_first_r <= WINDOW_FIRST_RST;
      win_last_r  <= WINDOW_LAST_RST;
      pos_r       <= '0;
      win_sum_r   <= '0;
      win_sq_r    <= '0;
      win_cnt_r   <= '0;
      tot_r       <= '0;
    end else begin
      win_first_r <= win_first_nxt;
      win_last_r  <= win_last_nxt;
      pos_r       <= pos_nxt;
      win_sum_r   <= win_sum_nxt;
      win_sq_r    <= win_sq_nxt;
      win_cnt_r   <= win_cnt_nxt;
      tot_r       <= tot_nxt;
    end
  end

`ifndef ASSERT_OFF
  // Every sample counted in the window also advanced the position.
  a_cnt_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
    CMPW'(win_cnt_r) <= CMPW'(pos_r))
    else $error("window count exceeds sample position");
`endif

endmodule

[rtl/prpa_queue.sv]
`timescale 1ns / 1ps
// Short job queue between the front and the back end, held in flip-flops.
// Depends on prpa_pkg for its depth.
module prpa_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] data_in,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] data_out
);
  import prpa_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = cnt_r == CNT_W'(QUEUE_DEPTH);
  assign empty    = cnt_r == '0;
  assign data_out = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= data_in;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QUEUE_DEPTH))
    else $error("job queue holds more entries than its depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("job pushed into a full queue");
`endif

endmodule

[rtl/prpa_back.sv]
`timescale 1ns / 1ps
// Back end: takes one waveform's sums from the job queue and works out the
// pedestal, rms and area with a shared bit-serial divider and a square-root unit.
// Depends on prpa_pkg; fed by prpa_queue.
module prpa_back #(
  parameter int MAX_SAMPLES = prpa_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = prpa_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_empty,
  output logic                                 q_pop,
  input  logic [prpa_pkg::job_w(SAMPLE_BITS, MAX_SAMPLES)-1:0] q_data,
  output prpa_pkg::result_t                    res,
  output logic                                 res_valid,
  input  logic                                 out_pop
);
  import prpa_pkg::*;

  localparam int CW   = pos_w(MAX_SAMPLES);
  localparam int SW   = sum_w(SAMPLE_BITS);
  localparam int QW   = sq_w(SAMPLE_BITS);
  localparam int TW   = tot_w(SAMPLE_BITS, MAX_SAMPLES);
  localparam int NQW  = QW + NCNT_W;
  localparam int S2W  = 2 * SW;
  localparam int DW   = NQW + 8;
  localparam int PDW  = SW + 4;
  localparam int PEDW = SAMPLE_BITS + 4;
  localparam int RW   = DW + (DW % 2);
  localparam int DCW  = $clog2(DW + 1);
  localparam int CPW  = CW + PEDW;

  back_state_t       state_r, state_nxt;
  logic              res_valid_r, res_valid_nxt;
  result_t           res_r, res_nxt;

  logic [NCNT_W-1:0] n_r, n_nxt;
  logic [SW-1:0]     s_r, s_nxt;
  logic [QW-1:0]     sq_sum_r, sq_sum_nxt;
  logic [TW-1:0]     t_r, t_nxt;
  logic [CW-1:0]     c_r, c_nxt;
  logic [NQW-1:0]    nq_r, nq_nxt;
  logic [S2W-1:0]    s2_r, s2_nxt;
  logic [NN_W-1:0]   nn_r, nn_nxt;
  logic [PEDW-1:0]   ped_r, ped_nxt;
  logic [CPW-1:0]    cp_r, cp_nxt;
  logic              empty_r, empty_nxt;

  logic [DW-1:0]     div_dvd_r, div_dvd_nxt;
  logic [DW-1:0]     div_q_r, div_q_nxt;
  logic [NN_W-1:0]   div_rem_r, div_rem_nxt;
  logic [NN_W-1:0]   div_dvs_r, div_dvs_nxt;
  logic [DCW-1:0]    div_cnt_r, div_cnt_nxt;

  logic [RW-1:0]     sq_v_r, sq_v_nxt;
  logic [RW-1:0]     sq_res_r, sq_res_nxt;
  logic [RW-1:0]     sq_bit_r, sq_bit_nxt;

  logic [NCNT_W-1:0] j_n;
  logic [SW-1:0]     j_s;
  logic [QW-1:0]     j_q;
  logic [TW-1:0]     j_t;
  logic [CW-1:0]     j_c;

  logic [NN_W:0]     div_trial;
  logic              div_ge;
  logic [NN_W-1:0]   div_rem_step;
  logic [DW-1:0]     div_q_step;
  logic [RW-1:0]     sq_t;
  logic              sq_ge;
  logic [DW-1:0]     rms_dvd;
  logic [PEDW-1:0]   ped_q;
  logic [AREA_W-1:0] area;

  assign {j_n, j_s, j_q, j_t, j_c} = q_data;

  // One restoring division step: bring in the next dividend bit and try the divisor.
  assign div_trial    = {div_rem_r, div_dvd_r[DW-1]};
  assign div_ge       = div_trial >= {1'b0, div_dvs_r};
  assign div_rem_step = div_ge ? NN_W'(div_trial - {1'b0, div_dvs_r}) : NN_W'(div_trial);
  assign div_q_step   = {div_q_r[DW-2:0], div_ge};

  assign sq_t  = sq_res_r + sq_bit_r;
  assign sq_ge = sq_v_r >= sq_t;

  assign rms_dvd = {NQW'(nq_r - NQW'(s2_r)), 8'b0};
  assign ped_q   = div_q_r[PEDW-1:0];
  assign area    = AREA_W'({t_r, 4'b0}) - AREA_W'(cp_r);

  always_comb begin
    state_nxt     = state_r;
    res_valid_nxt = res_valid_r & ~out_pop;
    res_nxt       = res_r;
    q_pop         = 1'b0;
    n_nxt         = n_r;
    s_nxt         = s_r;
    sq_sum_nxt    = sq_sum_r;
    t_nxt         = t_r;
    c_nxt         = c_r;
    nq_nxt        = nq_r;
    s2_nxt        = s2_r;
    nn_nxt        = nn_r;
    ped_nxt       = ped_r;
    cp_nxt        = cp_r;
    empty_nxt     = empty_r;
    div_dvd_nxt   = div_dvd_r;
    div_q_nxt     = div_q_r;
    div_rem_nxt   = div_rem_r;
    div_dvs_nxt   = div_dvs_r;
    div_cnt_nxt   = div_cnt_r;
    sq_v_nxt      = sq_v_r;
    sq_res_nxt    = sq_res_r;
    sq_bit_nxt    = sq_bit_r;

    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          n_nxt      = j_n;
          s_nxt      = j_s;
          sq_sum_nxt = j_q;
          t_nxt      = j_t;
          c_nxt      = j_c;
          state_nxt  = B_MUL;
        end
      end
      B_MUL: begin
        nq_nxt      = NQW'(n_r) * NQW'(sq_sum_r);
        s2_nxt      = S2W'(s_r) * S2W'(s_r);
        nn_nxt      = NN_W'(n_r) * NN_W'(n_r);
        empty_nxt   = n_r == '0;
        // Pedestal division: 16 * S over n, dividend aligned to the top.
        div_dvd_nxt = {s_r, {(DW - SW){1'b0}}};
        div_q_nxt   = '0;
        div_rem_nxt = '0;
        div_dvs_nxt = NN_W'(n_r);
        div_cnt_nxt = DCW'(PDW);
        state_nxt   = (n_r == '0) ? B_FIN : B_PDIV;
      end
      B_PDIV: begin
        div_dvd_nxt = div_dvd_r << 1;
        div_q_nxt   = div_q_step;
        div_rem_nxt = div_rem_step;
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == DCW'(1)) begin
          state_nxt = B_SUB;
        end
      end
      B_SUB: begin
        ped_nxt = ped_q;
        cp_nxt  = CPW'(c_r) * CPW'(ped_q);
        if (nq_r > NQW'(s2_r)) begin
          div_dvd_nxt = rms_dvd;
          div_q_nxt   = '0;
          div_rem_nxt = '0;
          div_dvs_nxt = nn_r;
          div_cnt_nxt = DCW'(DW);
          state_nxt   = B_RDIV;
        end else begin
          sq_res_nxt = '0;
          state_nxt  = B_FIN;
        end
      end
      B_RDIV: begin
        div_dvd_nxt = div_dvd_r << 1;
        div_q_nxt   = div_q_step;
        div_rem_nxt = div_rem_step;
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == DCW'(1)) begin
          sq_v_nxt   = RW'(div_q_step);
          sq_res_nxt = '0;
          sq_bit_nxt = RW'(1) << (RW - 2);
          state_nxt  = B_SQRT;
        end
      end
      B_SQRT: begin
        if (sq_ge) begin
          sq_v_nxt   = sq_v_r - sq_t;
          sq_res_nxt = (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_nxt = sq_res_r >> 1;
        end
        sq_bit_nxt = sq_bit_r >> 2;
        if (sq_bit_r[0]) begin
          state_nxt = B_FIN;
        end
      end
      B_FIN: begin
        // The finished result waits here only while the output register is still taken.
        if (!res_valid_r || out_pop) begin
          if (empty_r) begin
            res_nxt = '{ped: '0, rms: '0, area: '0, empty: 1'b1};
          end else begin
            res_nxt = '{ped: PED_W'(ped_r), rms: RMS_W'(sq_res_r), area: area,
                        empty: 1'b0};
          end
          res_valid_nxt = 1'b1;
          state_nxt     = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r     <= res_nxt;
    n_r       <= n_nxt;
    s_r       <= s_nxt;
    sq_sum_r  <= sq_sum_nxt;
    t_r       <= t_nxt;
    c_r       <= c_nxt;
    nq_r      <= nq_nxt;
    s2_r      <= s2_nxt;
    nn_r      <= nn_nxt;
    ped_r     <= ped_nxt;
    cp_r      <= cp_nxt;
    empty_r   <= empty_nxt;
    div_dvd_r <= div_dvd_nxt;
    div_q_r   <= div_q_nxt;
    div_rem_r <= div_rem_nxt;
    div_dvs_r <= div_dvs_nxt;
    div_cnt_r <= div_cnt_nxt;
    sq_v_r    <= sq_v_nxt;
    sq_res_r  <= sq_res_nxt;
    sq_bit_r  <= sq_bit_nxt;
  end

  assign res       = res_r;
  assign res_valid = res_valid_r;

`ifndef ASSERT_OFF
  a_res_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(res_valid_r) |-> $past(state_r == B_FIN))
    else $error("result appeared without passing the final state");

  a_sqrt_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_SQRT) |-> $onehot(sq_bit_r))
    else $error("square-root trial bit is not one-hot");
`endif

endmodule

[rtl/pedestal_rms_pulse_area.sv]
`timescale 1ns / 1ps
// Pedestal, rms noise and pulse area of one digitiser channel waveform.
// Input channel (in_push / in_full): one ADC sample per transaction, in_last_sample
// marking the final sample of the waveform. Samples are taken one per clock
// whenever in_full is low; positions beyond MAX_SAMPLES are not accumulated.
// Result channel (out_empty / out_pop): one transaction per waveform carrying
// pedestal, rms and area, all with 4 fraction bits, and the empty-window flag.
// Configuration (cfg_wr_en / cfg_index / cfg_data): window first and last position,
// one per write, written by the user only while the block is idle; the block has no check for it.
// The back end's bit-serial divider runs up to twice per waveform (pedestal, then
// variance over n squared): once when the variance is not positive, and not at all
// for an empty window. The square-root unit retires two radicand bits a cycle. The
// back end takes one waveform at a time and pops the next from the job queue only
// once the last one's result is in the output register; two finished waveforms
// wait in the job queue, after which in_full rises.
// A result that is not popped holds in the output register while the back end
// finishes the next waveform and then waits. Reset clears the accumulators,
// the queue and the output, and sets the window to positions 0 to 5.
module pedestal_rms_pulse_area #(
  parameter int MAX_SAMPLES = prpa_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = prpa_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [prpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prpa_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [13:0]                    in_sample_value,
  input  logic                           in_last_sample,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [prpa_pkg::PED_W-1:0]     out_pedestal_x16,
  output logic [prpa_pkg::RMS_W-1:0]     out_rms_x16,
  output logic signed [prpa_pkg::AREA_W-1:0] out_area_x16,
  output logic                           out_window_empty
);
  import prpa_pkg::*;

  localparam int JW = job_w(SAMPLE_BITS, MAX_SAMPLES);

  logic          job_push;
  logic [JW-1:0] job_data;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  logic [JW-1:0] q_data;
  result_t       res;
  logic          res_valid;
  logic          res_pop;

  assign in_full = q_full;
  assign res_pop = out_pop & res_valid;

  prpa_front #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_push         (in_push),
    .in_full         (q_full),
    .in_sample_value (in_sample_value),
    .in_last_sample  (in_last_sample),
    .job_push        (job_push),
    .job_data        (job_data)
  );

  prpa_queue #(
    .WIDTH (JW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .data_in  (job_data),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .data_out (q_data)
  );

  prpa_back #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .res       (res),
    .res_valid (res_valid),
    .out_pop   (res_pop)
  );

  assign out_empty        = ~res_valid;
  assign out_pedestal_x16 = res.ped;
  assign out_rms_x16      = res.rms;
  assign out_area_x16     = $signed(res.area);
  assign out_window_empty = res.empty;

endmodule

[bench/prpa_checker.sv]
`timescale 1ns / 1ps
// Checker for pedestal_rms_pulse_area: follows the window registers and both
// queue channels, predicts each waveform's result and compares it field by field.
// Depends on prpa_pkg for widths, register indexes and the result record.
module prpa_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [prpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [prpa_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               in_push,
  input  logic                               in_full,
  input  logic [13:0]                        in_sample_value,
  input  logic                               in_last_sample,
  input  logic                               out_empty,
  input  logic                               out_pop,
  input  logic [prpa_pkg::PED_W-1:0]         out_pedestal_x16,
  input  logic [prpa_pkg::RMS_W-1:0]         out_rms_x16,
  input  logic signed [prpa_pkg::AREA_W-1:0] out_area_x16,
  input  logic                               out_window_empty,
  output int                                 mismatches,
  output int                                 awaited,
  output int                                 checked,
  output int                                 empties
);
  import prpa_pkg::*;

  localparam int unsigned MAX_POS = MAX_SAMPLES_DEF;

  logic [CFG_W-1:0] win_first;
  logic [CFG_W-1:0] win_last;
  int unsigned      position;
  int unsigned      win_count;
  longint unsigned  win_sum;
  longint unsigned  win_sq_sum;
  longint unsigned  total;
  result_t          waveform_q[$];

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // The variance is taken as (n*Q - S*S) / n^2 so that it stays exact in integers.
  function automatic result_t close_waveform();
    result_t         r;
    longint unsigned n;
    longint unsigned ped;
    longint unsigned nq;
    longint unsigned s2;
    longint unsigned rms;
    longint          area;
    r = '0;
    if (win_count == 0) begin
      r.empty = 1'b1;
    end else begin
      n   = win_count;
      ped = (64'd16 * win_sum) / n;
      nq  = n * win_sq_sum;
      s2  = win_sum * win_sum;
      rms = 0;
      if (nq > s2) rms = floor_sqrt((64'd256 * (nq - s2)) / (n * n));
      area = longint'(64'd16 * total) - longint'(position) * longint'(ped);
      r.ped   = ped[PED_W-1:0];
      r.rms   = rms[RMS_W-1:0];
      r.area  = area[AREA_W-1:0];
      r.empty = 1'b0;
    end
    return r;
  endfunction

  task automatic clear_waveform();
    position   = 0;
    win_count  = 0;
    win_sum    = 0;
    win_sq_sum = 0;
    total      = 0;
  endtask

  // Samples past the last position are dropped, but their end flag still counts.
  task automatic take_sample(input logic [13:0] value, input logic last);
    longint unsigned x;
    x = value;
    if (position < MAX_POS) begin
      if (position >= win_first && position <= win_last) begin
        win_sum    += x;
        win_sq_sum += x * x;
        win_count++;
      end
      total += x;
      position++;
    end
    if (last) begin
      waveform_q.push_back(close_waveform());
      clear_waveform();
    end
  endtask

  task automatic report_field(input string field, input logic signed [31:0] want,
                              input logic signed [31:0] got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      win_first  = WINDOW_FIRST_RST;
      win_last   = WINDOW_LAST_RST;
      clear_waveform();
      waveform_q.delete();
      mismatches = 0;
      checked    = 0;
      empties    = 0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_WINDOW_FIRST) win_first = cfg_data;
        else if (cfg_index == CFG_WINDOW_LAST) win_last = cfg_data;
      end
      if (in_push && !in_full) take_sample(in_sample_value, in_last_sample);
      if (out_pop && !out_empty) begin
        if (waveform_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got ped=%0d rms=%0d area=%0d empty=%0d",
                   $time, out_pedestal_x16, out_rms_x16, out_area_x16, out_window_empty);
          mismatches++;
        end else begin
          want = waveform_q.pop_front();
          checked++;
          if (want.empty) empties++;
          if (out_pedestal_x16 !== want.ped)
            report_field("pedestal_x16", want.ped, out_pedestal_x16);
          if (out_rms_x16 !== want.rms)
            report_field("rms_x16", want.rms, out_rms_x16);
          if (out_area_x16 !== $signed(want.area))
            report_field("area_x16", $signed(want.area), out_area_x16);
          if (out_window_empty !== want.empty)
            report_field("window_empty", want.empty, out_window_empty);
        end
      end
    end
    awaited = waveform_q.size();
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Top of the pedestal_rms_pulse_area bench: clock, reset, window settings,
// waveform stimulus and the result-side pop pattern, plus the final verdict.
// Depends on prpa_pkg, the block itself and prpa_checker.
module tb_top;
  import prpa_pkg::*;

  localparam int WAVE_SAMPLES  = MAX_SAMPLES_DEF;
  localparam int TOP_VALUE     = 16383;
  localparam int STIM_TARGET   = 1700;
  localparam int SETTLE_CYCLES = 120;

  typedef enum int {STYLE_UNIFORM, STYLE_FLAT, STYLE_RAIL, STYLE_PULSE} wave_style_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = CFG_WINDOW_FIRST;
  logic [CFG_W-1:0]            cfg_data = '0;
  logic                        in_push = 1'b0;
  logic                        in_full;
  logic [13:0]                 in_sample_value = '0;
  logic                        in_last_sample = 1'b0;
  logic                        out_empty;
  logic                        out_pop = 1'b0;
  logic [PED_W-1:0]            out_pedestal_x16;
  logic [RMS_W-1:0]            out_rms_x16;
  logic signed [AREA_W-1:0]    out_area_x16;
  logic                        out_window_empty;

  int mismatches;
  int awaited;
  int checked;
  int empties;
  int samples_sent = 0;
  int waves_sent = 0;
  int long_waves = 0;
  int settings_used = 0;
  bit send_calm = 1'b0;
  bit pop_calm = 1'b0;
  int pop_gap = 0;
  int pop_count = 0;

  pedestal_rms_pulse_area i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_sample_value  (in_sample_value),
    .in_last_sample   (in_last_sample),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_pedestal_x16 (out_pedestal_x16),
    .out_rms_x16      (out_rms_x16),
    .out_area_x16     (out_area_x16),
    .out_window_empty (out_window_empty)
  );

  prpa_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_sample_value  (in_sample_value),
    .in_last_sample   (in_last_sample),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_pedestal_x16 (out_pedestal_x16),
    .out_rms_x16      (out_rms_x16),
    .out_area_x16     (out_area_x16),
    .out_window_empty (out_window_empty),
    .mismatches       (mismatches),
    .awaited          (awaited),
    .checked          (checked),
    .empties          (empties)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver: a random pause after each transaction, with calm stretches in between.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_gap = 0;
    end else begin
      if (out_pop && !out_empty) begin
        pop_count++;
        if (pop_count % 24 == 0) pop_calm = !pop_calm;
        pop_gap = pop_calm ? 0 : $urandom_range(0, 3);
      end
      if (pop_gap > 0) begin
        out_pop <= 1'b0;
        pop_gap--;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Idle cycles carry random data, which the block must ignore.
  task automatic send_sample(input logic [13:0] value, input logic last);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      in_push         <= 1'b0;
      in_sample_value <= 14'($urandom);
      in_last_sample  <= 1'($urandom);
      @(posedge clk);
    end
    in_push         <= 1'b1;
    in_sample_value <= value;
    in_last_sample  <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    samples_sent++;
    if (last) waves_sent++;
  endtask

  task automatic send_waveform(input int len, input wave_style_t style);
    int base;
    int v;
    base = $urandom_range(0, TOP_VALUE);
    for (int i = 0; i < len; i++) begin
      case (style)
        STYLE_FLAT: v = base;
        STYLE_RAIL: v = $urandom_range(0, 1) ? TOP_VALUE : 0;
        STYLE_PULSE: begin
          v = base + $urandom_range(0, 16) - 8;
          if (i >= len / 2 && i < len / 2 + 4) v += $urandom_range(0, 4000);
        end
        default: v = $urandom_range(0, TOP_VALUE);
      endcase
      if (v < 0) v = 0;
      if (v > TOP_VALUE) v = TOP_VALUE;
      send_sample(14'(v), i == len - 1);
    end
    if (len > WAVE_SAMPLES) long_waves++;
  endtask

  // Waits until every expected result has been popped and the block has gone quiet.
  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(input logic [CFG_W-1:0] first, input logic [CFG_W-1:0] last);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_WINDOW_FIRST;
    cfg_data  <= first;
    @(posedge clk);
    cfg_index <= CFG_WINDOW_LAST;
    cfg_data  <= last;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int phase;
    int phase_end;
    int len;
    int wf;
    int wl;
    phase = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset window of positions 0 to 5.
    send_calm = 1'b1;
    send_sample(14'(TOP_VALUE), 1'b1);
    send_sample(14'd0, 1'b1);
    repeat (6) send_sample(14'(TOP_VALUE), 1'b0);
    send_sample(14'(TOP_VALUE), 1'b1);
    for (int i = 0; i < 6; i++) send_sample((i % 2) ? 14'(TOP_VALUE) : 14'd0, 1'b0);
    send_sample(14'h2aaa, 1'b1);

    // First position beyond the last one: the window is empty.
    settle();
    set_window(5'd31, 5'd0);
    repeat (3) send_sample(14'h1555, 1'b0);
    send_sample(14'h3fff, 1'b1);

    // Window lying past the end of a short waveform.
    settle();
    set_window(5'd20, 5'd31);
    send_sample(14'd100, 1'b0);
    send_sample(14'd200, 1'b0);
    send_sample(14'd300, 1'b1);

    // Random part, one window setting per phase.
    while (samples_sent < STIM_TARGET) begin
      settle();
      case (phase)
        0: set_window(5'd0, 5'd31);
        1: set_window(5'd31, 5'd31);
        2: set_window(5'd0, 5'd0);
        3: set_window(5'd0, 5'd5);
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            wf = $urandom_range(0, 31);
            wl = $urandom_range(0, 31);
          end else begin
            wf = $urandom_range(0, 24);
            wl = wf + $urandom_range(0, 7);
          end
          set_window(5'(wf), 5'(wl));
        end
      endcase
      phase++;
      phase_end = samples_sent + $urandom_range(100, 250);
      while (samples_sent < phase_end && samples_sent < STIM_TARGET) begin
        send_calm = ($urandom_range(0, 7) == 0);
        len = $urandom_range(0, 19);
        if (len == 0) len = $urandom_range(WAVE_SAMPLES + 1, WAVE_SAMPLES + 8);
        else if (len <= 3) len = $urandom_range(1, 3);
        else len = $urandom_range(4, WAVE_SAMPLES);
        send_waveform(len, wave_style_t'($urandom_range(0, 3)));
      end
    end
    settle();

    $display("Sent %0d samples in %0d waveforms (%0d longer than %0d) over %0d window settings.",
             samples_sent, waves_sent, long_waves, WAVE_SAMPLES, settings_used);
    $display("Compared %0d results, %0d of them with an empty window.", checked, empties);
    if (mismatches == 0 && awaited == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Timeout with %0d results still outstanding.", awaited);
    $display("Some tests failed");
    $finish;
  end

endmodule

[sim.f]
rtl/prpa_pkg.sv
rtl/prpa_front.sv
rtl/prpa_queue.sv
rtl/prpa_back.sv
rtl/pedestal_rms_pulse_area.sv
bench/prpa_checker.sv
bench/tb_top.sv
